// ===== design/pinhole_camera_ray_generator_assert.svh =====
// Assertion macros for the pinhole camera ray generator.
`ifndef PINHOLE_CAMERA_RAY_GENERATOR_ASSERT_SVH
`define PINHOLE_CAMERA_RAY_GENERATOR_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define PCRG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define PCRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pcrg_pkg.sv =====
// Shared constants, types and helpers of the pinhole camera ray generator.
`default_nettype none

package pcrg_pkg;

  localparam int IDX_W        = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int SIDE_REG_W   = 13;
  localparam int WORD_W       = 32;
  localparam int MAG_W        = 63;
  localparam int C_W          = 31;
  localparam int SUM_W        = 64;
  localparam int ROOT_W       = 32;
  localparam int DIRQ_W       = 31;
  localparam int NORM_TOP     = 30;
  localparam int DEF_MAX_SIDE = 4096;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [SIDE_REG_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [SIDE_REG_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [WORD_W-1:0]     RST_ONE    = 32'h0001_0000;

  localparam logic [MAG_W-1:0]  MAG_CAP = 63'h4000_0000_0000_0000;
  localparam logic [DIRQ_W-1:0] ONE_Q30 = 31'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_FOCAL_LENGTH = 3'd2,
    CFG_HALF_FOV_TAN = 3'd3,
    CFG_CAMERA_X     = 3'd4,
    CFG_CAMERA_Y     = 3'd5,
    CFG_CAMERA_Z     = 3'd6
  } cfg_idx_t;

  // Clamp a wide signed value into the signed word range.
  function automatic logic [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic [WORD_W-1:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = 32'h8000_0000;
    end else begin
      res = v[WORD_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/pcrg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
`default_nettype none

module pcrg_div #(
  parameter int QUO_W = 24,
  parameter int DEN_W = 13,
  parameter int TAG_W = 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [QUO_W+DEN_W-1:0] in_num,
  input  wire logic [DEN_W-1:0]       in_den,
  input  wire logic [TAG_W-1:0]       in_tag,
  output logic                        out_valid,
  output logic [QUO_W-1:0]            out_quo,
  output logic [DEN_W-1:0]            out_rem,
  output logic [TAG_W-1:0]            out_tag
);

  logic                 vld_r [QUO_W];
  logic [DEN_W-1:0]     rem_r [QUO_W];
  logic [QUO_W-1:0]     low_r [QUO_W];
  logic [DEN_W-1:0]     den_r [QUO_W];
  logic [TAG_W-1:0]     tag_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             v_in;
    logic [DEN_W-1:0] r_in;
    logic [QUO_W-1:0] l_in;
    logic [DEN_W-1:0] d_in;
    logic [TAG_W-1:0] t_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = in_num[QUO_W+DEN_W-1:QUO_W];
      assign l_in = in_num[QUO_W-1:0];
      assign d_in = in_den;
      assign t_in = in_tag;
    end else begin : g_next
      assign v_in = vld_r[k-1];
      assign r_in = rem_r[k-1];
      assign l_in = low_r[k-1];
      assign d_in = den_r[k-1];
      assign t_in = tag_r[k-1];
    end

    // Shift in the next numerator bit and try the subtract
    assign trial = {r_in, l_in[QUO_W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_r[k] <= {l_in[QUO_W-2:0], ge};
        den_r[k] <= d_in;
        tag_r[k] <= t_in;
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_quo   = low_r[QUO_W-1];
  assign out_rem   = rem_r[QUO_W-1];
  assign out_tag   = tag_r[QUO_W-1];

endmodule

`default_nettype wire

// ===== design/pcrg_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a side tag.
`default_nettype none

module pcrg_sqrt
  import pcrg_pkg::*;
#(
  parameter int RT_W  = ROOT_W,
  parameter int TAG_W = 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [2*RT_W-1:0]   in_radicand,
  input  wire logic [TAG_W-1:0]    in_tag,
  output logic                     out_valid,
  output logic [RT_W-1:0]          out_root,
  output logic [TAG_W-1:0]         out_tag
);

  logic                 vld_r  [RT_W];
  logic [RT_W-1:0]      root_r [RT_W];
  logic [RT_W+1:0]      rem_r  [RT_W];
  logic [2*RT_W-1:0]    rad_r  [RT_W];
  logic [TAG_W-1:0]     tag_r  [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    logic              v_in;
    logic [RT_W-1:0]   q_in;
    logic [RT_W+1:0]   r_in;
    logic [2*RT_W-1:0] s_in;
    logic [TAG_W-1:0]  t_in;
    logic [RT_W+3:0]   rn;
    logic [RT_W+3:0]   trial;
    logic [RT_W+3:0]   diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign q_in = '0;
      assign r_in = '0;
      assign s_in = in_radicand;
      assign t_in = in_tag;
    end else begin : g_next
      assign v_in = vld_r[k-1];
      assign q_in = root_r[k-1];
      assign r_in = rem_r[k-1];
      assign s_in = rad_r[k-1];
      assign t_in = tag_r[k-1];
    end

    // Bring down two radicand bits and test the next root bit
    assign rn    = {r_in, s_in[2*RT_W-1 -: 2]};
    assign trial = {2'b00, q_in, 2'b01};
    assign diff  = rn - trial;
    assign ge    = rn >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {q_in[RT_W-2:0], ge};
        rem_r[k]  <= ge ? diff[RT_W+1:0] : rn[RT_W+1:0];
        rad_r[k]  <= {s_in[2*RT_W-3:0], 2'b00};
        tag_r[k]  <= t_in;
      end
    end
  end

  assign out_valid = vld_r[RT_W-1];
  assign out_root  = root_r[RT_W-1];
  assign out_tag   = tag_r[RT_W-1];

endmodule

`default_nettype wire

// ===== design/pinhole_camera_ray_generator.sv =====
// Top level of the pinhole camera ray generator: config, pipeline and output.
// Usage:
// - Input channel: in_valid / in_stall carry a 24-bit linear pixel index.
// - Result channel: out_valid / out_stall carry origin (Q16.16), unit
//   direction (Q2.30) and index_error; one result per input, in order.
// - Config: cfg_we / cfg_index / cfg_data write one register per cycle;
//   write only while no ray is in flight.
// - Throughput: one pixel per cycle, no bubbles while out_stall is low.
// - Pipeline: the column/row divider (24 stages), the two scale dividers,
//   the square root (32 stages) and the three direction dividers
//   (31 stages), all one bit per stage.
// - Stall: while a result is held with out_stall high, the whole pipeline
//   freezes and in_stall is raised; nothing is lost or repeated.
// - Reset: rst_n (synchronous, active low) empties the pipeline and loads
//   640 x 480, focal length 1.0, tangent 1.0 and the camera at the origin.
`default_nettype none

module pinhole_camera_ray_generator
  import pcrg_pkg::*;
#(
  parameter int MAX_SIDE  = DEF_MAX_SIDE,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [IDX_W-1:0]         in_pixel_index,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [WORD_W-1:0]      out_origin_x,
  output logic signed [WORD_W-1:0]      out_origin_y,
  output logic signed [WORD_W-1:0]      out_origin_z,
  output logic signed [WORD_W-1:0]      out_direction_x,
  output logic signed [WORD_W-1:0]      out_direction_y,
  output logic signed [WORD_W-1:0]      out_direction_z,
  output logic                          out_index_error,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int CMP_W   = (SIDE_W > SIDE_REG_W) ? SIDE_W : SIDE_REG_W;
  localparam int AREA_W  = 2 * SIDE_W;
  localparam int ACMP_W  = (AREA_W > IDX_W) ? AREA_W : IDX_W;
  localparam int A_W     = 64 - FRAC_BITS;
  localparam int MAGQ_W  = A_W + SIDE_W;
  localparam int POS_W   = $clog2(MAG_W);

  typedef struct packed {
    logic [C_W-1:0]    c0;
    logic [C_W-1:0]    c1;
    logic [C_W-1:0]    c2;
    logic              negx;
    logic              negy;
    logic              err;
    logic              zero;
    logic [WORD_W-1:0] ox;
    logic [WORD_W-1:0] oy;
    logic [WORD_W-1:0] oz;
  } sq_tag_t;

  typedef struct packed {
    logic              negx;
    logic              negy;
    logic              err;
    logic              zero;
    logic [WORD_W-1:0] ox;
  } dir_tag_t;

  // ---------------------------------------------------------------- config
  logic [SIDE_REG_W-1:0] width_r, height_r;
  logic [WORD_W-1:0]     focal_r, tan_r, cam_x_r, cam_y_r, cam_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      focal_r  <= RST_ONE;
      tan_r    <= RST_ONE;
      cam_x_r  <= '0;
      cam_y_r  <= '0;
      cam_z_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[SIDE_REG_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[SIDE_REG_W-1:0];
        CFG_FOCAL_LENGTH: focal_r  <= cfg_data;
        CFG_HALF_FOV_TAN: tan_r    <= cfg_data;
        CFG_CAMERA_X:     cam_x_r  <= cfg_data;
        CFG_CAMERA_Y:     cam_y_r  <= cfg_data;
        CFG_CAMERA_Z:     cam_z_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the image sides and precompute the area and the plane scale
  logic [CMP_W-1:0]  w_ext, h_ext;
  logic [SIDE_W-1:0] w_cl, h_cl;
  logic [63:0]       ft;
  logic [SIDE_W-1:0] side_w_r, side_h_r;
  logic [AREA_W-1:0] area_r;
  logic [A_W-1:0]    a_r;

  assign w_ext = CMP_W'(width_r);
  assign h_ext = CMP_W'(height_r);
  assign w_cl  = (w_ext > CMP_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : w_ext[SIDE_W-1:0];
  assign h_cl  = (h_ext > CMP_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : h_ext[SIDE_W-1:0];
  assign ft    = focal_r * tan_r;

  always_ff @(posedge clk) begin
    side_w_r <= w_cl;
    side_h_r <= h_cl;
    area_r   <= w_cl * h_cl;
    a_r      <= ft[63:FRAC_BITS];
  end

  // --------------------------------------------------------- flow control
  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Stage 0: capture the transfer
  logic             v0_r;
  logic [IDX_W-1:0] idx0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx0_r <= in_pixel_index;
    end
  end

  // Stage 1: range check against the image area
  logic             v1_r, err1_r;
  logic [IDX_W-1:0] idx1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r <= idx0_r;
      err1_r <= ACMP_W'(idx0_r) >= ACMP_W'(area_r);
    end
  end

  // Split index into row and column
  logic              vd1, errd1;
  logic [IDX_W-1:0]  row_d1;
  logic [SIDE_W-1:0] col_d1;

  pcrg_div #(.QUO_W(IDX_W), .DEN_W(SIDE_W), .TAG_W(1)) u_div_idx (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v1_r), .in_num({SIDE_W'(0), idx1_r}), .in_den(side_w_r), .in_tag(err1_r),
    .out_valid(vd1), .out_quo(row_d1), .out_rem(col_d1), .out_tag(errd1)
  );

  // Stage 2: signed offsets from the image center
  logic [SIDE_W:0]   x2, wx2;
  logic [IDX_W:0]    y2, hy2;
  logic              negx_c, negy_c;
  logic [SIDE_W:0]   nx_c;
  logic [IDX_W:0]    ny_c;
  logic              v2_r, negx2_r, negy2_r, err2_r;
  logic [SIDE_W-1:0] nx2_r, ny2_r;

  assign x2     = {col_d1, 1'b0};
  assign wx2    = {1'b0, side_w_r};
  assign negx_c = x2 > wx2;
  assign nx_c   = negx_c ? (x2 - wx2) : (wx2 - x2);
  assign y2     = {row_d1, 1'b0};
  assign hy2    = (IDX_W+1)'(side_h_r);
  assign negy_c = y2 < hy2;
  assign ny_c   = negy_c ? (hy2 - y2) : (y2 - hy2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= vd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negx2_r <= negx_c;
      negy2_r <= negy_c;
      err2_r  <= errd1;
      nx2_r   <= nx_c[SIDE_W-1:0];
      ny2_r   <= ny_c[SIDE_W-1:0];
    end
  end

  // Stage 3: scale by the plane factor
  logic              v3_r, negx3_r, negy3_r, err3_r;
  logic [MAGQ_W-1:0] px3_r, py3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negx3_r <= negx2_r;
      negy3_r <= negy2_r;
      err3_r  <= err2_r;
      px3_r   <= a_r * nx2_r;
      py3_r   <= a_r * ny2_r;
    end
  end

  // Divide both products by the image height
  logic              vd2, vd3, negxd2, errd2, negyd3;
  logic [MAGQ_W-1:0] qx_d2, qy_d3;

  pcrg_div #(.QUO_W(MAGQ_W), .DEN_W(SIDE_W), .TAG_W(2)) u_div_x (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v3_r), .in_num({SIDE_W'(0), px3_r}), .in_den(side_h_r),
    .in_tag({negx3_r, err3_r}),
    .out_valid(vd2), .out_quo(qx_d2), .out_rem(), .out_tag({negxd2, errd2})
  );

  pcrg_div #(.QUO_W(MAGQ_W), .DEN_W(SIDE_W), .TAG_W(1)) u_div_y (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v3_r), .in_num({SIDE_W'(0), py3_r}), .in_den(side_h_r),
    .in_tag(negy3_r),
    .out_valid(vd3), .out_quo(qy_d3), .out_rem(), .out_tag(negyd3)
  );

  // Stage 4: saturate magnitudes and form the origins
  logic [MAG_W-1:0] magx_c, magy_c;

  if (MAGQ_W >= MAG_W) begin : g_sat
    assign magx_c = (qx_d2 > MAGQ_W'(MAG_CAP)) ? MAG_CAP : qx_d2[MAG_W-1:0];
    assign magy_c = (qy_d3 > MAGQ_W'(MAG_CAP)) ? MAG_CAP : qy_d3[MAG_W-1:0];
  end else begin : g_nosat
    assign magx_c = MAG_W'(qx_d2);
    assign magy_c = MAG_W'(qy_d3);
  end

  logic signed [SUM_W-1:0] sx_c, sy_c, relx_c, rely_c, relz_c;

  assign sx_c   = $signed({1'b0, magx_c});
  assign sy_c   = $signed({1'b0, magy_c});
  assign relx_c = negxd2 ? -sx_c : sx_c;
  assign rely_c = negyd3 ? -sy_c : sy_c;
  assign relz_c = $signed(SUM_W'(focal_r));

  logic              v4_r, negx4_r, negy4_r, err4_r;
  logic [MAG_W-1:0]  mag0_4r, mag1_4r, mag2_4r;
  logic [WORD_W-1:0] ox4_r, oy4_r, oz4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= vd2 && vd3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negx4_r <= negxd2;
      negy4_r <= negyd3;
      err4_r  <= errd2;
      mag0_4r <= magx_c;
      mag1_4r <= magy_c;
      mag2_4r <= MAG_W'(focal_r);
      ox4_r   <= sat_word(relx_c + SUM_W'($signed(cam_x_r)));
      oy4_r   <= sat_word(rely_c + SUM_W'($signed(cam_y_r)));
      oz4_r   <= sat_word(relz_c + SUM_W'($signed(cam_z_r)));
    end
  end

  // Stage 5: largest magnitude
  logic [MAG_W-1:0]  m01_c;
  logic              v5_r, negx5_r, negy5_r, err5_r;
  logic [MAG_W-1:0]  mag0_5r, mag1_5r, mag2_5r, m5_r;
  logic [WORD_W-1:0] ox5_r, oy5_r, oz5_r;

  assign m01_c = (mag1_4r > mag0_4r) ? mag1_4r : mag0_4r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negx5_r <= negx4_r;
      negy5_r <= negy4_r;
      err5_r  <= err4_r;
      mag0_5r <= mag0_4r;
      mag1_5r <= mag1_4r;
      mag2_5r <= mag2_4r;
      m5_r    <= (mag2_4r > m01_c) ? mag2_4r : m01_c;
      ox5_r   <= ox4_r;
      oy5_r   <= oy4_r;
      oz5_r   <= oz4_r;
    end
  end

  // Stage 6: find the leading one and the normalizing shift
  logic [POS_W-1:0]  lead_c;
  logic              v6_r, negx6_r, negy6_r, err6_r, zero6_r, rsh6_r;
  logic [POS_W-1:0]  amt6_r;
  logic [MAG_W-1:0]  mag0_6r, mag1_6r, mag2_6r;
  logic [WORD_W-1:0] ox6_r, oy6_r, oz6_r;

  always_comb begin
    lead_c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m5_r[i]) begin
        lead_c = POS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negx6_r <= negx5_r;
      negy6_r <= negy5_r;
      err6_r  <= err5_r;
      zero6_r <= (m5_r == '0);
      rsh6_r  <= lead_c > POS_W'(NORM_TOP);
      amt6_r  <= (lead_c > POS_W'(NORM_TOP)) ? (lead_c - POS_W'(NORM_TOP))
                                              : (POS_W'(NORM_TOP) - lead_c);
      mag0_6r <= mag0_5r;
      mag1_6r <= mag1_5r;
      mag2_6r <= mag2_5r;
      ox6_r   <= ox5_r;
      oy6_r   <= oy5_r;
      oz6_r   <= oz5_r;
    end
  end

  // Stage 7: normalize all three magnitudes by the common shift
  logic [MAG_W-1:0]  n0_c, n1_c, n2_c;
  logic              v7_r, negx7_r, negy7_r, err7_r, zero7_r;
  logic [C_W-1:0]    c0_7r, c1_7r, c2_7r;
  logic [WORD_W-1:0] ox7_r, oy7_r, oz7_r;

  assign n0_c = rsh6_r ? (mag0_6r >> amt6_r) : (mag0_6r << amt6_r);
  assign n1_c = rsh6_r ? (mag1_6r >> amt6_r) : (mag1_6r << amt6_r);
  assign n2_c = rsh6_r ? (mag2_6r >> amt6_r) : (mag2_6r << amt6_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negx7_r <= negx6_r;
      negy7_r <= negy6_r;
      err7_r  <= err6_r;
      zero7_r <= zero6_r;
      c0_7r   <= n0_c[C_W-1:0];
      c1_7r   <= n1_c[C_W-1:0];
      c2_7r   <= n2_c[C_W-1:0];
      ox7_r   <= ox6_r;
      oy7_r   <= oy6_r;
      oz7_r   <= oz6_r;
    end
  end

  // Stage 8: squares
  logic                v8_r;
  logic [2*C_W-1:0]    sq0_8r, sq1_8r, sq2_8r;
  sq_tag_t             tag8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq0_8r <= c0_7r * c0_7r;
      sq1_8r <= c1_7r * c1_7r;
      sq2_8r <= c2_7r * c2_7r;
      tag8_r <= '{c0: c0_7r, c1: c1_7r, c2: c2_7r, negx: negx7_r, negy: negy7_r,
                  err: err7_r, zero: zero7_r, ox: ox7_r, oy: oy7_r, oz: oz7_r};
    end
  end

  // Stage 9: sum of squares
  logic             v9_r;
  logic [SUM_W-1:0] sum9_r;
  sq_tag_t          tag9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum9_r <= SUM_W'(sq0_8r) + SUM_W'(sq1_8r) + SUM_W'(sq2_8r);
      tag9_r <= tag8_r;
    end
  end

  // Vector length
  logic              vsq;
  logic [ROOT_W-1:0] len_sq;
  sq_tag_t           tag_sq;

  pcrg_sqrt #(.RT_W(ROOT_W), .TAG_W($bits(sq_tag_t))) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v9_r), .in_radicand(sum9_r), .in_tag(tag9_r),
    .out_valid(vsq), .out_root(len_sq), .out_tag(tag_sq)
  );

  // Stage 10: rounded numerators for the unit direction
  localparam int DNUM_W = DIRQ_W + ROOT_W;
  localparam int DPAD_W = DNUM_W - C_W - NORM_TOP;

  logic              v10_r;
  logic [DNUM_W-1:0] num0_10r, num1_10r, num2_10r;
  logic [ROOT_W-1:0] len10_r;
  dir_tag_t          dtag10_r;
  logic [WORD_W-1:0] oy10_r, oz10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (en) begin
      v10_r <= vsq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0_10r <= {DPAD_W'(0), tag_sq.c0, NORM_TOP'(0)} + DNUM_W'(len_sq >> 1);
      num1_10r <= {DPAD_W'(0), tag_sq.c1, NORM_TOP'(0)} + DNUM_W'(len_sq >> 1);
      num2_10r <= {DPAD_W'(0), tag_sq.c2, NORM_TOP'(0)} + DNUM_W'(len_sq >> 1);
      len10_r  <= len_sq;
      dtag10_r <= '{negx: tag_sq.negx, negy: tag_sq.negy, err: tag_sq.err,
                    zero: tag_sq.zero, ox: tag_sq.ox};
      oy10_r   <= tag_sq.oy;
      oz10_r   <= tag_sq.oz;
    end
  end

  // Divide each component by the length
  logic              vd4, vd5, vd6;
  logic [DIRQ_W-1:0] q0_d, q1_d, q2_d;
  dir_tag_t          dtag_d;
  logic [WORD_W-1:0] oy_d, oz_d;

  pcrg_div #(.QUO_W(DIRQ_W), .DEN_W(ROOT_W), .TAG_W($bits(dir_tag_t))) u_div_dx (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v10_r), .in_num(num0_10r), .in_den(len10_r), .in_tag(dtag10_r),
    .out_valid(vd4), .out_quo(q0_d), .out_rem(), .out_tag(dtag_d)
  );

  pcrg_div #(.QUO_W(DIRQ_W), .DEN_W(ROOT_W), .TAG_W(WORD_W)) u_div_dy (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v10_r), .in_num(num1_10r), .in_den(len10_r), .in_tag(oy10_r),
    .out_valid(vd5), .out_quo(q1_d), .out_rem(), .out_tag(oy_d)
  );

  pcrg_div #(.QUO_W(DIRQ_W), .DEN_W(ROOT_W), .TAG_W(WORD_W)) u_div_dz (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v10_r), .in_num(num2_10r), .in_den(len10_r), .in_tag(oz10_r),
    .out_valid(vd6), .out_quo(q2_d), .out_rem(), .out_tag(oz_d)
  );

  // Stage 11: cap, sign and clear on error (directions also on a zero vector) into the output register
  logic [DIRQ_W-1:0] d0_c, d1_c, d2_c;
  logic [WORD_W-1:0] dx_c, dy_c, dz_c;
  logic              blank_dir;

  assign d0_c = (q0_d > ONE_Q30) ? ONE_Q30 : q0_d;
  assign d1_c = (q1_d > ONE_Q30) ? ONE_Q30 : q1_d;
  assign d2_c = (q2_d > ONE_Q30) ? ONE_Q30 : q2_d;
  assign dx_c = dtag_d.negx ? -WORD_W'(d0_c) : WORD_W'(d0_c);
  assign dy_c = dtag_d.negy ? -WORD_W'(d1_c) : WORD_W'(d1_c);
  assign dz_c = WORD_W'(d2_c);
  assign blank_dir = dtag_d.err || dtag_d.zero;

  logic              err_r;
  logic [WORD_W-1:0] ox_r, oy_r, oz_r, dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd4 && vd5 && vd6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_r <= dtag_d.err;
      ox_r  <= dtag_d.err ? '0 : dtag_d.ox;
      oy_r  <= dtag_d.err ? '0 : oy_d;
      oz_r  <= dtag_d.err ? '0 : oz_d;
      dx_r  <= blank_dir ? '0 : dx_c;
      dy_r  <= blank_dir ? '0 : dy_c;
      dz_r  <= blank_dir ? '0 : dz_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_index_error = err_r;
  assign out_origin_x    = ox_r;
  assign out_origin_y    = oy_r;
  assign out_origin_z    = oz_r;
  assign out_direction_x = dx_r;
  assign out_direction_y = dy_r;
  assign out_direction_z = dz_r;

  // ------------------------------------------------------------ checks
  logic fields_zero, dir_bounded, lanes_aligned;

  assign fields_zero = out_origin_x == '0 && out_origin_y == '0 && out_origin_z == '0 &&
                       out_direction_x == '0 && out_direction_y == '0 &&
                       out_direction_z == '0;
  assign dir_bounded = out_direction_x <= 32'sh4000_0000 &&
                       out_direction_x >= -32'sh4000_0000 &&
                       out_direction_y <= 32'sh4000_0000 &&
                       out_direction_y >= -32'sh4000_0000 &&
                       out_direction_z <= 32'sh4000_0000 &&
                       out_direction_z >= -32'sh4000_0000;
  assign lanes_aligned = vd2 == vd3 && vd4 == vd5 && vd5 == vd6;

`include "pinhole_camera_ray_generator_assert.svh"

  `PCRG_ASSERT_NOW(a_err_clear, out_valid && out_index_error, fields_zero, "error result not clear")
  `PCRG_ASSERT_NOW(a_dir_bound, out_valid, dir_bounded, "direction component exceeds unit")
  `PCRG_ASSERT_NOW(a_lane_align, 1'b1, lanes_aligned, "parallel divider lanes out of step")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench of the pinhole camera ray generator.
`timescale 1ns / 1ps

module tb_top;
  import pcrg_pkg::*;

  typedef struct {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] direction_x;
    logic signed [31:0] direction_y;
    logic signed [31:0] direction_z;
    logic               index_error;
  } ray_t;

  // Predict rays from the register copy and match them against the block.
  class ray_scoreboard;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [31:0] focal_reg;
    logic [31:0] tan_reg;
    logic [31:0] cam_reg[3];
    ray_t        pending_rays[$];
    int          errors;

    function new();
      width_reg  = 13'd640;
      height_reg = 13'd480;
      focal_reg  = 32'h0001_0000;
      tan_reg    = 32'h0001_0000;
      foreach (cam_reg[i]) cam_reg[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = v[12:0];
        CFG_IMAGE_HEIGHT: height_reg = v[12:0];
        CFG_FOCAL_LENGTH: focal_reg  = v;
        CFG_HALF_FOV_TAN: tan_reg    = v;
        CFG_CAMERA_X:     cam_reg[0] = v;
        CFG_CAMERA_Y:     cam_reg[1] = v;
        CFG_CAMERA_Z:     cam_reg[2] = v;
        default: ;
      endcase
    endfunction

    // floor(a*n/d) with saturation at 2^62
    function longint unsigned scale_mag(longint unsigned a, longint unsigned n,
                                        longint unsigned d);
      longint unsigned cap, q, r, tot;
      cap = 64'd1 << 62;
      q = a / d;
      r = a % d;
      if (n != 0 && q > cap / n) return cap;
      tot = q * n + (r * n) / d;
      return (tot > cap) ? cap : tot;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function longint signed clamp32(longint signed v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function ray_t trace(logic [23:0] idx);
      longint unsigned w, h, x, y, p, a, m, sum, len, d, one;
      longint unsigned mag[3];
      longint unsigned c[3];
      bit              neg[3];
      longint signed   rel, s;
      logic [31:0]     os[3];
      logic [31:0]     ds[3];
      ray_t            r;
      r = '{default: '0};
      w = (width_reg > 13'd4096) ? 4096 : width_reg;
      h = (height_reg > 13'd4096) ? 4096 : height_reg;
      if (64'(idx) >= w * h) begin
        r.index_error = 1'b1;
        return r;
      end
      x = idx % w;
      y = idx / w;
      p = focal_reg;
      p = p * tan_reg;
      a = p >> 16;
      neg[0] = (2 * x) > w;
      mag[0] = scale_mag(a, neg[0] ? 2 * x - w : w - 2 * x, h);
      neg[1] = (2 * y) < h;
      mag[1] = scale_mag(a, neg[1] ? h - 2 * y : 2 * y - h, h);
      neg[2] = 1'b0;
      mag[2] = focal_reg;
      for (int i = 0; i < 3; i++) begin
        rel = neg[i] ? -longint'(mag[i]) : longint'(mag[i]);
        s = clamp32(rel + longint'($signed(cam_reg[i])));
        os[i] = s[31:0];
        ds[i] = '0;
      end
      m = mag[0];
      if (mag[1] > m) m = mag[1];
      if (mag[2] > m) m = mag[2];
      // normalize only a nonzero vector
      if (m != 0) begin
        one = 64'd1 << 30;
        for (int i = 0; i < 3; i++) c[i] = mag[i];
        while (m >= (64'd1 << 31)) begin
          m = m >> 1;
          for (int i = 0; i < 3; i++) c[i] = c[i] >> 1;
        end
        while (m < one) begin
          m = m << 1;
          for (int i = 0; i < 3; i++) c[i] = c[i] << 1;
        end
        sum = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
          d = (c[i] * one + len / 2) / len;
          if (d > one) d = one;
          s = neg[i] ? -longint'(d) : longint'(d);
          ds[i] = s[31:0];
        end
      end
      r.origin_x = os[0];
      r.origin_y = os[1];
      r.origin_z = os[2];
      r.direction_x = ds[0];
      r.direction_y = ds[1];
      r.direction_z = ds[2];
      return r;
    endfunction

    function void note_pixel(logic [23:0] idx);
      pending_rays.push_back(trace(idx));
    endfunction

    function void cmp(string name, longint signed want, longint signed got);
      if (want != got) begin
        $error("%s expected %0d actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_ray(ray_t got);
      ray_t want;
      if (pending_rays.size() == 0) begin
        $error("result transfer with no ray pending");
        errors++;
        return;
      end
      want = pending_rays.pop_front();
      cmp("origin_x", want.origin_x, got.origin_x);
      cmp("origin_y", want.origin_y, got.origin_y);
      cmp("origin_z", want.origin_z, got.origin_z);
      cmp("direction_x", want.direction_x, got.direction_x);
      cmp("direction_y", want.direction_y, got.direction_y);
      cmp("direction_z", want.direction_z, got.direction_z);
      cmp("index_error", want.index_error, got.index_error);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [IDX_W-1:0]   in_pixel_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_origin_x, out_origin_y, out_origin_z;
  logic signed [31:0] out_direction_x, out_direction_y, out_direction_z;
  logic               out_index_error;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ray_scoreboard sb = new();
  int idle_in  = 30;
  int idle_out = 45;

  pinhole_camera_ray_generator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel_index(in_pixel_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_origin_x(out_origin_x), .out_origin_y(out_origin_y),
    .out_origin_z(out_origin_z), .out_direction_x(out_direction_x),
    .out_direction_y(out_direction_y), .out_direction_z(out_direction_z),
    .out_index_error(out_index_error),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Check each result transfer, then pick the next stall.
  always @(posedge clk) begin
    ray_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.origin_x = out_origin_x;
      got.origin_y = out_origin_y;
      got.origin_z = out_origin_z;
      got.direction_x = out_direction_x;
      got.direction_y = out_direction_y;
      got.direction_z = out_direction_z;
      got.index_error = out_index_error;
      sb.check_ray(got);
    end
    out_stall <= ($urandom_range(99) < idle_out);
  end

  // Offer one pixel and hold it until the transfer.
  task automatic send_pixel(logic [23:0] idx);
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_index <= idx;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(idx);
  endtask

  // Drop valid and let the pipeline empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_rays.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Drive one register write; the caller drops the write enable.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic setup(logic [31:0] w, logic [31:0] h, logic [31:0] f,
                       logic [31:0] t, logic [31:0] cx, logic [31:0] cy,
                       logic [31:0] cz);
    drain();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_FOCAL_LENGTH, f);
    write_reg(CFG_HALF_FOV_TAN, t);
    write_reg(CFG_CAMERA_X, cx);
    write_reg(CFG_CAMERA_Y, cy);
    write_reg(CFG_CAMERA_Z, cz);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_side();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom_range(8191);
    if (sel < 4) return $urandom_range(64, 1);
    return $urandom_range(4096, 1);
  endfunction

  function automatic logic [31:0] pick_q16();
    int sel;
    sel = $urandom_range(3);
    if (sel == 0) return $urandom;
    return $urandom_range(32'h0004_0000, 32'h0000_1000);
  endfunction

  function automatic logic [23:0] pick_pixel();
    longint unsigned w, h, area;
    int sel;
    w = (sb.width_reg > 13'd4096) ? 4096 : sb.width_reg;
    h = (sb.height_reg > 13'd4096) ? 4096 : sb.height_reg;
    area = w * h;
    sel = $urandom_range(99);
    if (area == 0 || sel < 10) return 24'($urandom);
    if (sel < 20) return 24'((area + $urandom_range(3)) > 24'hFFFFFF ?
                             24'hFFFFFF : area + $urandom_range(3));
    return 24'($urandom_range(32'(area - 1)));
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset frame corners, center, first out-of-frame index
    send_pixel(24'd0);
    send_pixel(24'd639);
    send_pixel(24'd640);
    send_pixel(24'd320 + 24'd240 * 24'd640);
    send_pixel(24'd307199);
    send_pixel(24'd307200);
    send_pixel(24'hFFFFFF);
    // zero focal length gives zero direction
    setup(640, 480, 0, 32'h0001_0000, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_0000);
    send_pixel(24'd5);
    send_pixel(24'd1000);
    // empty image
    setup(0, 480, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
    send_pixel(24'd0);
    // oversized sides clamp to the maximum
    setup(8191, 8191, 32'h0002_0000, 32'h0000_8000, 0, 0, 0);
    send_pixel(24'd0);
    send_pixel(24'hFFFFFF);
    send_pixel(24'd4095);
    // single pixel
    setup(1, 1, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
    send_pixel(24'd0);
    send_pixel(24'd1);
    // saturating magnitudes and camera extremes
    setup(4096, 4096, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF);
    send_pixel(24'd0);
    send_pixel(24'hFFFFFF);
    setup(4096, 4096, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000);
    send_pixel(24'd0);
    send_pixel(24'hFFFFFF);

    // Random phases, each with fresh registers
    for (int ph = 0; ph < 9; ph++) begin
      idle_in  = (ph < 3) ? 30 : (ph < 6) ? 45 : 0;
      idle_out = (ph < 3) ? 45 : (ph < 6) ? 30 : 0;
      if (ph == 8)
        setup(640, 480, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
      else
        setup(pick_side(), pick_side(), pick_q16(), pick_q16(),
              $urandom, $urandom, $urandom);
      for (int k = 0; k < 210; k++) begin
        if (ph == 4 && k == 100) drain();
        send_pixel(pick_pixel());
      end
    end

    drain();
    if (sb.pending_rays.size() != 0) begin
      $error("%0d rays never arrived", sb.pending_rays.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Hard stop on a hung run.
  initial begin
    #4_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/pcrg_pkg.sv
design/pcrg_div.sv
design/pcrg_sqrt.sv
design/pinhole_camera_ray_generator.sv
bench/tb_top.sv
